FILE: design/tlpt_pkg.sv
// Shared constants and control types for the two-level page table manager.
`timescale 1ns / 1ps

package tlpt_pkg;

   localparam int DIR_ENTRIES   = 1024;
   localparam int TABLE_ENTRIES = 1024;
   localparam int DIR_IDX_W     = 10;
   localparam int TBL_IDX_W     = 10;

   // Request codes.
   localparam logic [2:0] REQ_MAP_4K   = 3'd0;
   localparam logic [2:0] REQ_MAP_4M   = 3'd1;
   localparam logic [2:0] REQ_UNMAP    = 3'd2;
   localparam logic [2:0] REQ_XLATE    = 3'd3;
   localparam logic [2:0] REQ_SET_WR   = 3'd4;

   // Status codes.
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NOT_READY  = 3'd1;
   localparam logic [2:0] ST_MISALIGNED = 3'd2;
   localparam logic [2:0] ST_NO_TABLE   = 3'd3;
   localparam logic [2:0] ST_ABSENT     = 3'd4;

   // Entry flag bits.
   localparam logic [31:0] E_PRESENT  = 32'h0000_0001;
   localparam logic [31:0] E_WRITABLE = 32'h0000_0002;
   localparam logic [31:0] E_HUGE     = 32'h0000_0080;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;      // clearing pass: zero one pool entry and one directory entry
      logic accept;     // latch request, read directory
      logic tbl_issue;  // read second-level table entry
      logic commit;     // write back and load the response register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last; // last entry of the clearing pass
      logic out_free;   // response register can take a new result
   } dp_sts_type;

endpackage

FILE: design/tlpt_if.sv
// Channel interfaces of the page table manager: request, response and register write.
`timescale 1ns / 1ps

interface tlpt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [31:0] virt_addr;
   logic [31:0] phys_addr;
   logic [11:0] entry_flags;

   modport source (output valid, req_type, virt_addr, phys_addr, entry_flags, input ready);
   modport sink   (input valid, req_type, virt_addr, phys_addr, entry_flags, output ready);
endinterface

interface tlpt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] phys_out;
   logic        flush_valid;
   logic [19:0] flush_page;

   modport source (output valid, status, phys_out, flush_valid, flush_page, input ready);
   modport sink   (input valid, status, phys_out, flush_valid, flush_page, output ready);
endinterface

interface tlpt_csr_if;
   logic valid;
   logic ready;
   logic paging_ready;

   modport source (output valid, paging_ready, input ready);
   modport sink   (input valid, paging_ready, output ready);
endinterface

FILE: design/tlpt_ctrl.sv
// Sequencing state machine of the page table manager.
`timescale 1ns / 1ps

module tlpt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tlpt_pkg::dp_sts_type   sts,
   output tlpt_pkg::dp_cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_DIR   = 4'b0100,
      S_TBL   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = S_DIR;
            end
         end
         S_DIR: begin
            cmd.tbl_issue = 1'b1;
            state_in      = S_TBL;
         end
         S_TBL: begin
            // Hold here while the previous response is still waiting.
            cmd.commit = sts.out_free;
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/tlpt_datapath.sv
// Directory and table memories, request decode and response register.
`timescale 1ns / 1ps

module tlpt_datapath #(
   parameter int TABLE_SLOTS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tlpt_pkg::dp_cmd_type   cmd,
   output tlpt_pkg::dp_sts_type   sts,
   input  logic [2:0]             req_type,
   input  logic [31:0]            virt_addr,
   input  logic [31:0]            phys_addr,
   input  logic [11:0]            entry_flags,
   input  logic                   csr_write,
   input  logic                   csr_paging_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_status,
   output logic [31:0]            rsp_phys_out,
   output logic                   rsp_flush_valid,
   output logic [19:0]            rsp_flush_page
);

   localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W      = $clog2(TABLE_SLOTS + 1);
   localparam int PA_W       = SLOT_W + tlpt_pkg::TBL_IDX_W;
   localparam int POOL_DEPTH = TABLE_SLOTS * tlpt_pkg::TABLE_ENTRIES;

   logic [31:0] dir_mem  [tlpt_pkg::DIR_ENTRIES];
   logic [31:0] pool_mem [POOL_DEPTH];

   logic                 paging_ready_ff;
   logic [2:0]           type_ff;
   logic [31:0]          virt_ff;
   logic [31:0]          phys_ff;
   logic [11:0]          flags_ff;
   logic [31:0]          dir_q_ff;
   logic [31:0]          tbl_q_ff;
   logic [PA_W-1:0]      tbl_addr_ff;
   logic [PA_W-1:0]      clear_cnt_ff;
   logic [CNT_W-1:0]     next_free_ff;

   logic                 rsp_valid_ff;
   logic [2:0]           rsp_status_ff;
   logic [31:0]          rsp_phys_ff;
   logic                 rsp_flush_ff;
   logic [19:0]          rsp_page_ff;

   logic                 dpres, huge, slot_ok, need_alloc, exhausted, misaligned;
   logic [SLOT_W-1:0]    tbl_slot;
   logic [PA_W-1:0]      tbl_ra;
   logic [31:0]          new_dent;

   logic [2:0]           status_in;
   logic [31:0]          pout_in;
   logic                 flush_in;
   logic                 alloc;
   logic                 op_dir_we, op_pool_we;
   logic [31:0]          op_dir_wd, op_pool_wd;

   logic                          dir_we, pool_we;
   logic [tlpt_pkg::DIR_IDX_W-1:0] dir_wa;
   logic [PA_W-1:0]               pool_wa;
   logic [31:0]                   dir_wd, pool_wd;

   // Walk decode from the registered directory entry.
   always_comb begin
      dpres      = dir_q_ff[0];
      huge       = dpres && dir_q_ff[7];
      slot_ok    = dir_q_ff[31:12] < 20'(TABLE_SLOTS);
      need_alloc = !dpres || !slot_ok;
      exhausted  = next_free_ff == CNT_W'(TABLE_SLOTS);
      misaligned = (virt_ff[21:0] != 22'd0) || (phys_ff[21:0] != 22'd0);
      tbl_slot   = need_alloc ? next_free_ff[SLOT_W-1:0] : dir_q_ff[12 +: SLOT_W];
      tbl_ra     = {tbl_slot, virt_ff[21:12]};
      new_dent   = {{(20 - CNT_W){1'b0}}, next_free_ff, 12'h000}
                   | tlpt_pkg::E_PRESENT | tlpt_pkg::E_WRITABLE;
   end

   always_comb begin
      status_in  = tlpt_pkg::ST_OK;
      pout_in    = 32'd0;
      flush_in   = 1'b0;
      alloc      = 1'b0;
      op_dir_we  = 1'b0;
      op_dir_wd  = 32'd0;
      op_pool_we = 1'b0;
      op_pool_wd = 32'd0;
      if (!paging_ready_ff) begin
         status_in = tlpt_pkg::ST_NOT_READY;
      end else begin
         unique case (type_ff) inside
            tlpt_pkg::REQ_MAP_4K: begin
               if (huge) begin
                  status_in = tlpt_pkg::ST_ABSENT;
               end else if (need_alloc && exhausted) begin
                  status_in = tlpt_pkg::ST_NO_TABLE;
               end else begin
                  op_pool_we = 1'b1;
                  op_pool_wd = {phys_ff[31:12], 12'h000} | tlpt_pkg::E_PRESENT
                               | {20'd0, flags_ff};
                  flush_in   = 1'b1;
                  if (need_alloc) begin
                     alloc     = 1'b1;
                     op_dir_we = 1'b1;
                     op_dir_wd = new_dent;
                  end
               end
            end
            tlpt_pkg::REQ_MAP_4M: begin
               if (misaligned) begin
                  status_in = tlpt_pkg::ST_MISALIGNED;
               end else begin
                  op_dir_we = 1'b1;
                  op_dir_wd = {phys_ff[31:22], 22'd0} | tlpt_pkg::E_PRESENT
                              | tlpt_pkg::E_HUGE | {20'd0, flags_ff};
                  flush_in  = 1'b1;
               end
            end
            tlpt_pkg::REQ_XLATE: begin
               if (!dpres) begin
                  status_in = tlpt_pkg::ST_ABSENT;
               end else if (huge) begin
                  pout_in = {dir_q_ff[31:22], virt_ff[21:0]};
               end else if (!slot_ok || !tbl_q_ff[0]) begin
                  status_in = tlpt_pkg::ST_ABSENT;
               end else begin
                  pout_in = {tbl_q_ff[31:12], virt_ff[11:0]};
               end
            end
            tlpt_pkg::REQ_UNMAP, tlpt_pkg::REQ_SET_WR: begin
               if (!dpres || huge || !slot_ok || !tbl_q_ff[0]) begin
                  status_in = tlpt_pkg::ST_ABSENT;
               end else begin
                  op_pool_we = 1'b1;
                  op_pool_wd = (type_ff == tlpt_pkg::REQ_UNMAP) ? 32'd0
                               : (tbl_q_ff | tlpt_pkg::E_WRITABLE);
                  flush_in   = 1'b1;
               end
            end
            default: begin
               status_in = tlpt_pkg::ST_ABSENT;
            end
         endcase
      end
   end

   // Memory write ports: the clearing pass or the commit of a request.
   always_comb begin
      dir_we  = cmd.clear || (cmd.commit && op_dir_we);
      pool_we = cmd.clear || (cmd.commit && op_pool_we);
      dir_wa  = cmd.clear ? clear_cnt_ff[tlpt_pkg::DIR_IDX_W-1:0] : virt_ff[31:22];
      pool_wa = cmd.clear ? clear_cnt_ff : tbl_addr_ff;
      dir_wd  = cmd.clear ? 32'd0 : op_dir_wd;
      pool_wd = cmd.clear ? 32'd0 : op_pool_wd;
   end

   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[dir_wa] <= dir_wd;
      end
      if (cmd.accept) begin
         dir_q_ff <= dir_mem[virt_addr[31:22]];
      end
   end

   always_ff @(posedge clock) begin
      if (pool_we) begin
         pool_mem[pool_wa] <= pool_wd;
      end
      if (cmd.tbl_issue) begin
         tbl_q_ff <= pool_mem[tbl_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         type_ff  <= req_type;
         virt_ff  <= virt_addr;
         phys_ff  <= phys_addr;
         flags_ff <= entry_flags;
      end
      if (cmd.tbl_issue) begin
         tbl_addr_ff <= tbl_ra;
      end
      if (cmd.commit) begin
         rsp_status_ff <= status_in;
         rsp_phys_ff   <= pout_in;
         rsp_flush_ff  <= flush_in;
         rsp_page_ff   <= flush_in ? virt_ff[31:12] : 20'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         paging_ready_ff <= 1'b0;
         clear_cnt_ff    <= '0;
         next_free_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            paging_ready_ff <= csr_paging_ready;
         end
         if (cmd.clear) begin
            clear_cnt_ff <= clear_cnt_ff + PA_W'(1);
         end
         if (cmd.commit && alloc) begin
            next_free_ff <= next_free_ff + CNT_W'(1);
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.clear_last = clear_cnt_ff == PA_W'(POOL_DEPTH - 1);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_phys_out    = rsp_phys_ff;
   assign rsp_flush_valid = rsp_flush_ff;
   assign rsp_flush_page  = rsp_page_ff;

   a_pool_count: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= CNT_W'(TABLE_SLOTS))
      else $error("table pool counter ran past the pool size");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result committed over a response still waiting");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

   a_flush_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_flush_ff || (rsp_phys_ff != 32'd0)))
         |-> (rsp_status_ff == tlpt_pkg::ST_OK))
      else $error("flush or address reported on a failed request");

endmodule

FILE: design/two_level_page_table_manager.sv
// Top level of the two-level page table manager.
// The block holds a 1024-entry page directory and a pool of TABLE_SLOTS
// second-level tables and serves map, unmap, translate and mark-writable
// requests on the req_chan channel, one response per request on rsp_chan.
// A request is taken on a rising edge with valid and ready both high.
// Each request passes the directory read, the dependent table read and
// the write-back that also loads the response register, in that order;
// the next request is taken only once the write-back is done. Both
// memories have one read and one write port.
// The csr_chan port writes paging_ready and is always ready; the user must
// write it only while no request is in flight, which the block does not enforce.
// After reset the block runs a clearing pass over the TABLE_SLOTS * 1024
// entries of the table pool (65536 at the default), one entry a cycle,
// clearing the directory alongside it; req_chan.ready stays low until it
// ends. A stalled response holds in its register; the next request is still
// taken and waits in its write-back state until the response is taken.
`timescale 1ns / 1ps

module two_level_page_table_manager #(
   parameter int TABLE_SLOTS = 64
) (
   input  logic         clock,
   input  logic         reset,
   tlpt_req_if.sink     req_chan,
   tlpt_rsp_if.source   rsp_chan,
   tlpt_csr_if.sink     csr_chan
);

   tlpt_pkg::dp_cmd_type cmd;
   tlpt_pkg::dp_sts_type sts;

   assign csr_chan.ready = 1'b1;

   tlpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tlpt_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_chan.req_type),
      .virt_addr        (req_chan.virt_addr),
      .phys_addr        (req_chan.phys_addr),
      .entry_flags      (req_chan.entry_flags),
      .csr_write        (csr_chan.valid),
      .csr_paging_ready (csr_chan.paging_ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_status       (rsp_chan.status),
      .rsp_phys_out     (rsp_chan.phys_out),
      .rsp_flush_valid  (rsp_chan.flush_valid),
      .rsp_flush_page   (rsp_chan.flush_page)
   );

endmodule
